>>> src/gfqg_pkg.sv
// Shared types, constants and the optional-field check for the GNSS fix quality gate.
package gfqg_pkg;

   localparam int unsigned FLD_W     = 10;
   localparam int unsigned REJ_W     = 11;
   localparam int unsigned ACC_W     = 32;
   localparam int unsigned LIM_W     = 31;
   localparam int unsigned TIME_W    = 64;
   localparam int unsigned AGE_LIM_W = 26;   // 65535 ms * 1000 fits in 26 bits

   localparam logic [9:0] MS_TO_US   = 10'd1000;
   localparam logic [7:0] FIX_3D     = 8'd3;
   localparam logic [7:0] FIX_GNSS_DR = 8'd4;

   // field bits of the support and validity masks
   localparam int unsigned F_FIXTYPE = 0;
   localparam int unsigned F_FIXOK   = 1;
   localparam int unsigned F_POS     = 2;
   localparam int unsigned F_HEIGHT  = 3;
   localparam int unsigned F_SATS    = 4;
   localparam int unsigned F_HACC    = 5;
   localparam int unsigned F_VACC    = 6;
   localparam int unsigned F_SACC    = 7;
   localparam int unsigned F_VELH    = 8;
   localparam int unsigned F_VELV    = 9;

   // reject mask bits
   localparam int unsigned R_OFFLINE = 0;
   localparam int unsigned R_NOFIX   = 1;
   localparam int unsigned R_FIXTYPE = 2;
   localparam int unsigned R_FIXFLAG = 3;
   localparam int unsigned R_UNSUP   = 4;
   localparam int unsigned R_INVALID = 5;
   localparam int unsigned R_STALE   = 6;
   localparam int unsigned R_SATS    = 7;
   localparam int unsigned R_HACC    = 8;
   localparam int unsigned R_VACC    = 9;
   localparam int unsigned R_SACC    = 10;

   typedef enum logic [2:0] {
      CSR_MIN_SATS = 3'd0,
      CSR_MAX_AGE  = 3'd1,
      CSR_MAX_HACC = 3'd2,
      CSR_MAX_VACC = 3'd3,
      CSR_MAX_SACC = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [7:0]       min_sats;
      logic [15:0]      max_age_ms;
      logic [LIM_W-1:0] max_hacc;
      logic [LIM_W-1:0] max_vacc;
      logic [LIM_W-1:0] max_sacc;
   } cfg_type;

   // after stage 1: age difference and fix-type decode
   typedef struct packed {
      logic [FLD_W-1:0]     sup;
      logic [FLD_W-1:0]     val;
      logic                 online;
      logic                 kind_ok;
      logic                 good;
      logic [7:0]           sats;
      logic [ACC_W-1:0]     hacc;
      logic [ACC_W-1:0]     vacc;
      logic [ACC_W-1:0]     sacc;
      logic [2:0]           nf;
      logic                 ts_ok;
      logic [TIME_W-1:0]    age_us;
      logic [AGE_LIM_W-1:0] age_lim;
   } s1_type;

   // after stage 2: all value checks reduced to flags
   typedef struct packed {
      logic [FLD_W-1:0] sup;
      logic [FLD_W-1:0] val;
      logic             online;
      logic             kind_ok;
      logic             good;
      logic             sats_low;
      logic             hacc_bad;
      logic             vacc_bad;
      logic             sacc_bad;
      logic             fresh;
   } s2_type;

   typedef struct packed {
      logic [REJ_W-1:0] mask;
      logic             blk;
      logic             deg;
   } opt_res_type;

   // optional field: unsupported degrades, invalid or failing value blocks
   function automatic opt_res_type opt_check(input logic sup, input logic val,
                                             input logic bad, input int unsigned reason);
      opt_res_type res;
      res = '0;
      if (!sup) begin
         res.mask[R_UNSUP] = 1'b1;
         res.deg           = 1'b1;
      end else if (!val) begin
         res.mask[reason]    = 1'b1;
         res.mask[R_INVALID] = 1'b1;
         res.blk             = 1'b1;
      end else if (bad) begin
         res.mask[reason] = 1'b1;
         res.blk          = 1'b1;
      end
      return res;
   endfunction

endpackage

>>> src/gfqg_csr.sv
// Configuration registers with write port.
module gfqg_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [30:0]          csr_wdata,
   output gfqg_pkg::cfg_type    cfg
);

   gfqg_pkg::cfg_type cfg_ff;
   gfqg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            gfqg_pkg::CSR_MIN_SATS: cfg_in.min_sats   = csr_wdata[7:0];
            gfqg_pkg::CSR_MAX_AGE:  cfg_in.max_age_ms = csr_wdata[15:0];
            gfqg_pkg::CSR_MAX_HACC: cfg_in.max_hacc   = csr_wdata;
            gfqg_pkg::CSR_MAX_VACC: cfg_in.max_vacc   = csr_wdata;
            gfqg_pkg::CSR_MAX_SACC: cfg_in.max_sacc   = csr_wdata;
            default:                cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_sats   <= 8'd6;
         cfg_ff.max_age_ms <= 16'd500;
         cfg_ff.max_hacc   <= 31'd5000;
         cfg_ff.max_vacc   <= 31'd8000;
         cfg_ff.max_sacc   <= 31'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/gfqg_front.sv
// Stages 1 and 2: sample age arithmetic and value compares.
module gfqg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  gfqg_pkg::cfg_type    cfg,
   input  logic                 req_online,
   input  logic [9:0]           req_sup_mask,
   input  logic [9:0]           req_vld_mask,
   input  logic [7:0]           req_fix_kind,
   input  logic                 req_fix_good,
   input  logic [7:0]           req_sat_count,
   input  logic signed [31:0]   req_hacc_mm,
   input  logic signed [31:0]   req_vacc_mm,
   input  logic signed [31:0]   req_sacc_mmps,
   input  logic [2:0]           req_nonfinite_flags,
   input  logic [63:0]          req_sample_time_us,
   input  logic [63:0]          req_now_time_us,
   output gfqg_pkg::s2_type     s2,
   output logic                 s2_valid
);

   gfqg_pkg::s1_type s1_ff, s1_in;
   gfqg_pkg::s2_type s2_ff, s2_in;
   logic             s1_valid_ff, s2_valid_ff;

   // stage 1: 64-bit age subtract, age limit product
   always_comb begin
      s1_in.sup     = req_sup_mask;
      s1_in.val     = req_vld_mask;
      s1_in.online  = req_online;
      s1_in.kind_ok = (req_fix_kind == gfqg_pkg::FIX_3D) ||
                      (req_fix_kind == gfqg_pkg::FIX_GNSS_DR);
      s1_in.good    = req_fix_good;
      s1_in.sats    = req_sat_count;
      s1_in.hacc    = req_hacc_mm;
      s1_in.vacc    = req_vacc_mm;
      s1_in.sacc    = req_sacc_mmps;
      s1_in.nf      = req_nonfinite_flags;
      s1_in.ts_ok   = (req_sample_time_us != '0) && (req_sample_time_us <= req_now_time_us);
      s1_in.age_us  = req_now_time_us - req_sample_time_us;
      s1_in.age_lim = gfqg_pkg::AGE_LIM_W'(cfg.max_age_ms) *
                      gfqg_pkg::AGE_LIM_W'(gfqg_pkg::MS_TO_US);
   end

   // stage 2: limit compares
   always_comb begin
      s2_in.sup      = s1_ff.sup;
      s2_in.val      = s1_ff.val;
      s2_in.online   = s1_ff.online;
      s2_in.kind_ok  = s1_ff.kind_ok;
      s2_in.good     = s1_ff.good;
      s2_in.sats_low = s1_ff.sats < cfg.min_sats;
      s2_in.hacc_bad = s1_ff.nf[0] || s1_ff.hacc[31] || (s1_ff.hacc[30:0] > cfg.max_hacc);
      s2_in.vacc_bad = s1_ff.nf[1] || s1_ff.vacc[31] || (s1_ff.vacc[30:0] > cfg.max_vacc);
      s2_in.sacc_bad = s1_ff.nf[2] || s1_ff.sacc[31] || (s1_ff.sacc[30:0] > cfg.max_sacc);
      s2_in.fresh    = s1_ff.ts_ok &&
                       (s1_ff.age_us[63:gfqg_pkg::AGE_LIM_W] == '0) &&
                       (s1_ff.age_us[gfqg_pkg::AGE_LIM_W-1:0] <= s1_ff.age_lim);
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign s2       = s2_ff;
   assign s2_valid = s2_valid_ff;

endmodule

>>> src/gfqg_judge.sv
// Stage 3: reject mask assembly and result register.
module gfqg_judge (
   input  logic               clock,
   input  logic               reset,
   input  gfqg_pkg::s2_type   s2,
   input  logic               s2_valid,
   output logic               rsp_valid,
   output logic [10:0]        rsp_pos_reject,
   output logic [10:0]        rsp_vel_reject,
   output logic               rsp_pos_usable,
   output logic [2:0]         rsp_vel_valid,
   output logic               rsp_degraded
);

   logic [10:0] pos_reject_ff, pos_reject_in;
   logic [10:0] vel_reject_ff, vel_reject_in;
   logic        pos_usable_ff, pos_usable_in;
   logic [2:0]  vel_valid_ff, vel_valid_in;
   logic        degraded_ff, degraded_in;
   logic        valid_ff;

   always_comb begin
      logic [10:0] base;
      logic        base_blk;
      logic        pb, vb, deg;
      logic [2:0]  vv;
      gfqg_pkg::opt_res_type fixok_r, sats_r, hacc_r, vacc_r, sacc_r;

      base     = '0;
      base_blk = 1'b0;
      vv       = '0;

      if (!s2.online) begin
         base[gfqg_pkg::R_OFFLINE] = 1'b1;
         base_blk = 1'b1;
      end
      // fix type is mandatory
      if (!s2.sup[gfqg_pkg::F_FIXTYPE] || !s2.val[gfqg_pkg::F_FIXTYPE] || !s2.kind_ok) begin
         base[gfqg_pkg::R_NOFIX]   = 1'b1;
         base[gfqg_pkg::R_FIXTYPE] = 1'b1;
         base_blk = 1'b1;
      end
      if (!s2.sup[gfqg_pkg::F_FIXTYPE]) begin
         base[gfqg_pkg::R_UNSUP] = 1'b1;
      end else if (!s2.val[gfqg_pkg::F_FIXTYPE]) begin
         base[gfqg_pkg::R_INVALID] = 1'b1;
      end
      fixok_r = gfqg_pkg::opt_check(s2.sup[gfqg_pkg::F_FIXOK], s2.val[gfqg_pkg::F_FIXOK],
                                    !s2.good, gfqg_pkg::R_FIXFLAG);
      if (!s2.fresh) begin
         base[gfqg_pkg::R_STALE] = 1'b1;
         base_blk = 1'b1;
      end
      sats_r = gfqg_pkg::opt_check(s2.sup[gfqg_pkg::F_SATS], s2.val[gfqg_pkg::F_SATS],
                                   s2.sats_low, gfqg_pkg::R_SATS);
      base     = base | fixok_r.mask | sats_r.mask;
      base_blk = base_blk | fixok_r.blk | sats_r.blk;

      // position
      pos_reject_in = base;
      pb            = base_blk;
      if (!s2.sup[gfqg_pkg::F_POS] || !s2.sup[gfqg_pkg::F_HEIGHT]) begin
         pos_reject_in[gfqg_pkg::R_UNSUP] = 1'b1;
         pb = 1'b1;
      end else if (!s2.val[gfqg_pkg::F_POS] || !s2.val[gfqg_pkg::F_HEIGHT]) begin
         pos_reject_in[gfqg_pkg::R_INVALID] = 1'b1;
         pb = 1'b1;
      end
      hacc_r = gfqg_pkg::opt_check(s2.sup[gfqg_pkg::F_HACC], s2.val[gfqg_pkg::F_HACC],
                                   s2.hacc_bad, gfqg_pkg::R_HACC);
      vacc_r = gfqg_pkg::opt_check(s2.sup[gfqg_pkg::F_VACC], s2.val[gfqg_pkg::F_VACC],
                                   s2.vacc_bad, gfqg_pkg::R_VACC);
      pos_reject_in = pos_reject_in | hacc_r.mask | vacc_r.mask;
      pb            = pb | hacc_r.blk | vacc_r.blk;

      // velocity
      sacc_r = gfqg_pkg::opt_check(s2.sup[gfqg_pkg::F_SACC], s2.val[gfqg_pkg::F_SACC],
                                   s2.sacc_bad, gfqg_pkg::R_SACC);
      vel_reject_in = base | sacc_r.mask;
      vb            = base_blk | sacc_r.blk;
      deg = fixok_r.deg | sats_r.deg | hacc_r.deg | vacc_r.deg | sacc_r.deg;

      // horizontal velocity gates east/north; missing it blocks nothing by itself
      if (!s2.sup[gfqg_pkg::F_VELH]) begin
         vel_reject_in[gfqg_pkg::R_UNSUP] = 1'b1;
      end else if (!s2.val[gfqg_pkg::F_VELH]) begin
         vel_reject_in[gfqg_pkg::R_INVALID] = 1'b1;
      end else begin
         vv = 3'b011;
      end
      // up only rides on horizontal
      if (!s2.sup[gfqg_pkg::F_VELV]) begin
         vel_reject_in[gfqg_pkg::R_UNSUP] = 1'b1;
         deg = 1'b1;
      end else if (!s2.val[gfqg_pkg::F_VELV]) begin
         vel_reject_in[gfqg_pkg::R_INVALID] = 1'b1;
      end else if (vv != '0) begin
         vv[2] = 1'b1;
      end

      pos_usable_in = !pb;
      vel_valid_in  = vb ? 3'b000 : vv;
      degraded_in   = deg;
   end

   always_ff @(posedge clock) begin
      pos_reject_ff <= pos_reject_in;
      vel_reject_ff <= vel_reject_in;
      pos_usable_ff <= pos_usable_in;
      vel_valid_ff  <= vel_valid_in;
      degraded_ff   <= degraded_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s2_valid;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pos_reject = pos_reject_ff;
   assign rsp_vel_reject = vel_reject_ff;
   assign rsp_pos_usable = pos_usable_ff;
   assign rsp_vel_valid  = vel_valid_ff;
   assign rsp_degraded   = degraded_ff;

endmodule

>>> src/gnss_fix_quality_gate.sv
// Top level of the GNSS fix quality gate.
// A result strobes on rsp_valid once its item has passed the stage 1, stage 2 and result registers.
// Throughput: one item per cycle; busy stays low, every stage advances each cycle.
// Stages: age subtract and limit product, limit compares, mask assembly into
// the result register. Results cannot be held off by the receiver.
// Synchronous reset clears stage valids and restores the register defaults.
module gnss_fix_quality_gate (
   input  logic                 clock,
   input  logic                 reset,
   // item input
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_online,
   input  logic [9:0]           req_sup_mask,
   input  logic [9:0]           req_vld_mask,
   input  logic [7:0]           req_fix_kind,
   input  logic                 req_fix_good,
   input  logic [7:0]           req_sat_count,
   input  logic signed [31:0]   req_hacc_mm,
   input  logic signed [31:0]   req_vacc_mm,
   input  logic signed [31:0]   req_sacc_mmps,
   input  logic [2:0]           req_nonfinite_flags,
   input  logic [63:0]          req_sample_time_us,
   input  logic [63:0]          req_now_time_us,
   // result output
   output logic                 rsp_valid,
   output logic [10:0]          rsp_pos_reject,
   output logic [10:0]          rsp_vel_reject,
   output logic                 rsp_pos_usable,
   output logic [2:0]           rsp_vel_valid,
   output logic                 rsp_degraded,
   // register write port
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [30:0]          csr_wdata
);

   gfqg_pkg::cfg_type cfg;
   gfqg_pkg::s2_type  s2;
   logic              s2_valid;
   logic              accept;

   // fully pipelined, never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   gfqg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stages 1-2: timestamps and limit compares
   gfqg_front u_front (
      .clock                (clock),
      .reset                (reset),
      .accept               (accept),
      .cfg                  (cfg),
      .req_online           (req_online),
      .req_sup_mask         (req_sup_mask),
      .req_vld_mask         (req_vld_mask),
      .req_fix_kind         (req_fix_kind),
      .req_fix_good         (req_fix_good),
      .req_sat_count        (req_sat_count),
      .req_hacc_mm          (req_hacc_mm),
      .req_vacc_mm          (req_vacc_mm),
      .req_sacc_mmps        (req_sacc_mmps),
      .req_nonfinite_flags  (req_nonfinite_flags),
      .req_sample_time_us   (req_sample_time_us),
      .req_now_time_us      (req_now_time_us),
      .s2                   (s2),
      .s2_valid             (s2_valid)
   );

   // stage 3: masks, usable flags, result register
   gfqg_judge u_judge (
      .clock          (clock),
      .reset          (reset),
      .s2             (s2),
      .s2_valid       (s2_valid),
      .rsp_valid      (rsp_valid),
      .rsp_pos_reject (rsp_pos_reject),
      .rsp_vel_reject (rsp_vel_reject),
      .rsp_pos_usable (rsp_pos_usable),
      .rsp_vel_valid  (rsp_vel_valid),
      .rsp_degraded   (rsp_degraded)
   );

endmodule

>>> src/gfqg_checker.sv
// Port-level checker for the GNSS fix quality gate, with its bind.
module gfqg_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        rsp_valid,
   input  logic [10:0] rsp_pos_reject,
   input  logic [10:0] rsp_vel_reject,
   input  logic        rsp_pos_usable,
   input  logic [2:0]  rsp_vel_valid
);

   a_item_in_result_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("item taken without result three cycles later");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result without matching item");

   a_usable_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pos_usable) |-> ((rsp_pos_reject & 11'h7EF) == 11'h000))
      else $error("position usable with a blocking reject bit");

   a_vel_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_vel_valid != 3'b000)) |->
         ((rsp_vel_valid[1:0] == 2'b11) && !rsp_vel_reject[0] && !rsp_vel_reject[6]))
      else $error("velocity valid mask inconsistent with rejects");

endmodule

bind gnss_fix_quality_gate gfqg_checker u_gfqg_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_pos_reject (rsp_pos_reject),
   .rsp_vel_reject (rsp_vel_reject),
   .rsp_pos_usable (rsp_pos_usable),
   .rsp_vel_valid  (rsp_vel_valid)
);
